>>> hdl/assert_macros.svh
// assertion macros shared by the responder rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define ASSERT_HOLDS(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
		else $error("assertion failed: condition does not hold");

// condition in one cycle implies another in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
		else $error("assertion failed: next-cycle implication");

`endif

>>> hdl/scmr_pkg.sv
// package: types, codes and reply tables of the codec message responder
`default_nettype none
package scmr_pkg;

	// frame parsing phases
	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_HEAD  = 2'd1;
	localparam logic [1:0] PH_BODY  = 2'd2;
	localparam logic [1:0] PH_REPLY = 2'd3;

	// error codes
	localparam logic [1:0] ERR_NONE    = 2'd0;
	localparam logic [1:0] ERR_IDLE    = 2'd1;
	localparam logic [1:0] ERR_LENGTH  = 2'd2;
	localparam logic [1:0] ERR_UNKNOWN = 2'd3;

	// framing bytes
	localparam logic [7:0] SYNC_BYTE = 8'hAA;
	localparam logic [7:0] ZERO_BYTE = 8'h00;
	localparam logic [15:0] SHORT_LEN = 16'd4;

	// configuration register
	localparam logic CFG_IDX_TZ = 1'b0;
	localparam logic [7:0] TZ_RESET = 8'd32;

	// largest accepted body length
	localparam int unsigned MAX_BODY_DEF = 2048;

	typedef struct packed {
		logic [1:0]  phase;
		logic [15:0] cnt;
		logic [7:0]  prev;
		logic [15:0] flen;
		logic [15:0] fid;
		logic        pend;
		logic [2:0]  kind;
	} state_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       reply_last;
		logic       irq_pulse;
		logic [1:0] error_code;
	} result_t;

	// request id to reply kind, msb flags a known id
	function automatic logic [3:0] id_lookup(input logic [15:0] id);
		logic [3:0] r;
		unique case (id)
			16'h0080: r = 4'b1_000;
			16'h0082: r = 4'b1_001;
			16'h00A0: r = 4'b1_010;
			16'h0003: r = 4'b1_011;
			16'h0008: r = 4'b1_100;
			16'h0010: r = 4'b1_101;
			16'h0062: r = 4'b1_110;
			16'h0064: r = 4'b1_111;
			default:  r = 4'b0_000;
		endcase
		return r;
	endfunction

	// payload length of each reply kind
	function automatic logic [2:0] rsp_len(input logic [2:0] kind);
		logic [2:0] r;
		case (kind)
			3'd0, 3'd1: r = 3'd1;
			3'd2:       r = 3'd4;
			default:    r = 3'd2;
		endcase
		return r;
	endfunction

	// reply id of each kind
	function automatic logic [15:0] rsp_id(input logic [2:0] kind);
		logic [15:0] r;
		case (kind)
			3'd0:    r = 16'h0081;
			3'd1:    r = 16'h0083;
			3'd2:    r = 16'h00A1;
			3'd3:    r = 16'h0004;
			3'd4:    r = 16'h0009;
			3'd5:    r = 16'h0011;
			3'd6:    r = 16'h0063;
			default: r = 16'h0065;
		endcase
		return r;
	endfunction

	// total reply bytes including the pad for odd payloads
	function automatic logic [3:0] rsp_size(input logic [2:0] kind);
		logic [2:0] len;
		len = rsp_len(kind);
		return 4'd6 + {1'b0, len} + {3'b000, len[0]};
	endfunction

	// byte at position idx of the reply frame
	function automatic logic [7:0] reply_byte(input logic [2:0] kind, input logic [3:0] idx);
		logic [7:0]  fs;
		logic [15:0] id;
		logic [7:0]  r;
		fs = 8'd4 + {5'b0, rsp_len(kind)};
		id = rsp_id(kind);
		case (idx) inside
			4'd0:         r = ZERO_BYTE;
			4'd1:         r = SYNC_BYTE;
			4'd2:         r = ZERO_BYTE;
			4'd3:         r = fs;
			4'd4:         r = id[15:8];
			4'd5:         r = id[7:0];
			4'd7:         r = (kind == 3'd0 || kind == 3'd1) ? 8'h01 :
			                  (kind == 3'd2) ? 8'h02 : 8'h00;
			default:      r = 8'h00;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

>>> hdl/scmr_cfg.sv
// apb register file holding the turnaround zero count
`default_nettype none
module scmr_cfg (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	output logic [7:0]       tz
);
	logic [7:0] tz_q;
	logic       wr_en;

	// write strobe on the access phase
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && (paddr[2] == scmr_pkg::CFG_IDX_TZ);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tz_q <= scmr_pkg::TZ_RESET;
		end else if (wr_en) begin
			tz_q <= pwdata[7:0];
		end
	end

	// read back
	assign prdata = (paddr[2] == scmr_pkg::CFG_IDX_TZ) ? {24'b0, tz_q} : 32'b0;
	assign tz     = tz_q;
endmodule
`default_nettype wire

>>> hdl/scmr_step.sv
// next-state and result logic for one spi byte transfer
`default_nettype none
module scmr_step #(
	parameter int unsigned MAX_BODY = scmr_pkg::MAX_BODY_DEF
) (
	input  wire scmr_pkg::state_t st,
	input  wire logic             cmd,
	input  wire logic [7:0]       rx_byte,
	input  wire logic [7:0]       tz,
	output scmr_pkg::state_t      nxt,
	output scmr_pkg::result_t     res
);
	localparam logic [15:0] MAX_LEN = 16'(MAX_BODY);

	logic [15:0] cnt_sat;
	logic [15:0] cnt_inc;
	logic [15:0] fid_full;
	logic [15:0] id_sel;
	logic [3:0]  look;
	logic        len_bad;
	logic [3:0]  size;

	// shared counter arithmetic and id lookup
	assign cnt_inc  = st.cnt + 16'd1;
	assign cnt_sat  = (st.cnt == 16'hFFFF) ? st.cnt : cnt_inc;
	assign fid_full = {st.fid[15:8], rx_byte};
	assign id_sel   = (st.phase == scmr_pkg::PH_HEAD) ? fid_full : st.fid;
	assign look     = scmr_pkg::id_lookup(id_sel);
	assign len_bad  = (st.flen == 16'd0) || (st.flen > MAX_LEN);
	assign size     = scmr_pkg::rsp_size(st.kind);

	// frame state machine
	always_comb begin
		nxt = st;
		res = '0;
		if (cmd) begin
			nxt.phase = scmr_pkg::PH_IDLE;
			nxt.cnt   = 16'd0;
			nxt.prev  = 8'd0;
			nxt.pend  = 1'b0;
		end else begin
			unique case (st.phase)
				scmr_pkg::PH_IDLE: begin
					if (st.prev == scmr_pkg::ZERO_BYTE && rx_byte == scmr_pkg::SYNC_BYTE) begin
						nxt.phase = scmr_pkg::PH_HEAD;
						nxt.cnt   = 16'd0;
					end else if (rx_byte == scmr_pkg::ZERO_BYTE) begin
						nxt.cnt = cnt_sat;
						if (cnt_sat >= {8'b0, tz} && st.pend) begin
							nxt.phase = scmr_pkg::PH_REPLY;
							nxt.cnt   = 16'd0;
						end
					end else begin
						res.error_code = scmr_pkg::ERR_IDLE;
						nxt.cnt        = 16'd0;
					end
				end
				scmr_pkg::PH_HEAD: begin
					case (st.cnt[1:0])
						2'd0: begin
							nxt.flen = {rx_byte, 8'b0};
							nxt.cnt  = 16'd1;
						end
						2'd1: begin
							nxt.flen = {st.flen[15:8], rx_byte};
							nxt.cnt  = 16'd2;
						end
						2'd2: begin
							nxt.fid = {rx_byte, 8'b0};
							nxt.cnt = 16'd3;
						end
						default: begin
							nxt.fid = fid_full;
							nxt.cnt = 16'd0;
							if (len_bad) begin
								res.error_code = scmr_pkg::ERR_LENGTH;
								nxt.phase      = scmr_pkg::PH_IDLE;
							end else if (st.flen == scmr_pkg::SHORT_LEN) begin
								nxt.phase = scmr_pkg::PH_IDLE;
								if (look[3]) begin
									nxt.kind      = look[2:0];
									nxt.pend      = 1'b1;
									res.irq_pulse = 1'b1;
								end else begin
									res.error_code = scmr_pkg::ERR_UNKNOWN;
								end
							end else begin
								nxt.phase = scmr_pkg::PH_BODY;
							end
						end
					endcase
				end
				scmr_pkg::PH_BODY: begin
					nxt.cnt = cnt_inc;
					if (cnt_inc >= st.flen) begin
						nxt.phase = scmr_pkg::PH_IDLE;
						nxt.cnt   = 16'd0;
						if (look[3]) begin
							nxt.kind      = look[2:0];
							nxt.pend      = 1'b1;
							res.irq_pulse = 1'b1;
						end else begin
							res.error_code = scmr_pkg::ERR_UNKNOWN;
						end
					end
				end
				default: begin
					res.tx_byte = scmr_pkg::reply_byte(st.kind, st.cnt[3:0]);
					nxt.cnt     = cnt_inc;
					if (cnt_inc >= {12'b0, size}) begin
						res.reply_last = 1'b1;
						nxt.phase      = scmr_pkg::PH_IDLE;
						nxt.cnt        = 16'd0;
						nxt.pend       = 1'b0;
					end
				end
			endcase
			nxt.prev = rx_byte;
		end
	end
endmodule
`default_nettype wire

>>> hdl/spi_codec_message_responder_unit.sv
// top level of the spi codec message responder
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+----------------------------------------
//   in      | to block  | in_valid/in_ready  | cmd, rx_byte
//   out     | from block| out_valid/out_ready| tx_byte, reply_last, irq_pulse, error_code
//   apb     | to block  | psel/penable       | paddr, pwdata, prdata
//
// one transfer in per cycle unless the result register stalls: input register,
// then the frame logic writes the result register and the frame state together.
// reset clears the frame state and loads the tz register with 32.
// a stalled result holds the result register; the input register takes the
// next byte as long as the result register drains or is empty.
`default_nettype none
`include "assert_macros.svh"
module spi_codec_message_responder_unit #(
	parameter int unsigned MAX_BODY = scmr_pkg::MAX_BODY_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        cmd,
	input  wire logic [7:0]  rx_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       tx_byte,
	output logic             reply_last,
	output logic             irq_pulse,
	output logic [1:0]       error_code
);
	logic              valid_s1;
	logic              cmd_s1;
	logic [7:0]        rx_s1;
	logic              valid_s2;
	scmr_pkg::result_t res_s2;
	scmr_pkg::state_t  st_q;
	scmr_pkg::state_t  st_nxt;
	scmr_pkg::result_t res;
	logic [7:0]        tz;
	logic              advance;
	logic              in_xfer;

	scmr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.tz      (tz)
	);

	scmr_step #(.MAX_BODY(MAX_BODY)) u_step (
		.st      (st_q),
		.cmd     (cmd_s1),
		.rx_byte (rx_s1),
		.tz      (tz),
		.nxt     (st_nxt),
		.res     (res)
	);

	// handshake control
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign in_xfer  = in_valid && in_ready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cmd_s1 <= cmd;
			rx_s1  <= rx_byte;
		end
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{phase: scmr_pkg::PH_IDLE, default: '0};
		end else if (advance) begin
			st_q <= st_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign out_valid  = valid_s2;
	assign tx_byte    = res_s2.tx_byte;
	assign reply_last = res_s2.reply_last;
	assign irq_pulse  = res_s2.irq_pulse;
	assign error_code = res_s2.error_code;

	// checks
	`ASSERT_HOLDS(a_reply_needs_pending, clk, arst_n,
		st_q.phase != scmr_pkg::PH_REPLY || st_q.pend)
	`ASSERT_HOLDS(a_irq_without_error, clk, arst_n,
		!valid_s2 || !res_s2.irq_pulse || res_s2.error_code == scmr_pkg::ERR_NONE)
	`ASSERT_HOLDS(a_head_count_bounded, clk, arst_n,
		st_q.phase != scmr_pkg::PH_HEAD || st_q.cnt[15:2] == 14'd0)
	`ASSERT_NEXT(a_pin_reset_clears, clk, arst_n, advance && cmd_s1,
		st_q.phase == scmr_pkg::PH_IDLE && !st_q.pend && st_q.cnt == 16'd0)
endmodule
`default_nettype wire
